@@ src/dbpr_pkg.sv @@
`default_nettype none

package dbpr_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int DEBOUNCE_WIDTH  = 16;
    localparam int INTERVAL_WIDTH  = 32;
    localparam int STAMP_WIDTH     = 32;
    localparam int COUNT_WIDTH     = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_LOW    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TIME = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_INTERVAL  = 2'd2;

    localparam logic                      ACTIVE_LOW_RESET    = 1'b1;
    localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_TIME_RESET = 16'd50;
    localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL_RESET  = 32'd2000;

    // Per-sample status produced by the update logic.
    typedef struct packed {
        logic raw;
        logic fire;
        logic confirmed;
    } dbpr_flags_t;

endpackage

`default_nettype wire

@@ src/dbpr_update.sv @@
`default_nettype none

module dbpr_update #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                                  active_low,
    input  wire logic [dbpr_pkg::DEBOUNCE_WIDTH-1:0]   debounce_time,
    input  wire logic [dbpr_pkg::INTERVAL_WIDTH-1:0]   min_interval,
    input  wire logic                                  pin_level,
    input  wire logic [TIME_WIDTH-1:0]                 now,
    input  wire logic                                  previous_raw,
    input  wire logic [TIME_WIDTH-1:0]                 change_stamp,
    input  wire logic                                  confirmed,
    input  wire logic [TIME_WIDTH-1:0]                 last_fire_stamp,
    input  wire logic [dbpr_pkg::COUNT_WIDTH-1:0]      press_count,
    output logic [TIME_WIDTH-1:0]                      change_stamp_next,
    output logic [TIME_WIDTH-1:0]                      last_fire_stamp_next,
    output logic [dbpr_pkg::COUNT_WIDTH-1:0]           press_count_next,
    output dbpr_pkg::dbpr_flags_t                      flags
);

    // Compare width covers both the time base and the 32-bit interval register.
    localparam int CMP_WIDTH = (TIME_WIDTH > dbpr_pkg::INTERVAL_WIDTH) ?
                               TIME_WIDTH : dbpr_pkg::INTERVAL_WIDTH;

    logic                  raw;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] since_fire;
    logic                  stable;
    logic                  interval_ok;

    always_comb
    begin
        raw               = active_low ? ~pin_level : pin_level;
        change_stamp_next = (raw != previous_raw) ? now : change_stamp;
        since_change      = now - change_stamp_next;
        since_fire        = now - last_fire_stamp;
        stable            = CMP_WIDTH'(since_change) >= CMP_WIDTH'(debounce_time);
        interval_ok       = CMP_WIDTH'(since_fire) >= CMP_WIDTH'(min_interval);

        last_fire_stamp_next = last_fire_stamp;
        press_count_next     = press_count;
        flags.raw            = raw;
        flags.fire           = 1'b0;
        flags.confirmed      = confirmed;

        if (stable)
        begin
            if (raw && !confirmed)
            begin
                // A press that comes too soon is still confirmed, only not reported.
                flags.confirmed = 1'b1;
                if (interval_ok)
                begin
                    flags.fire           = 1'b1;
                    last_fire_stamp_next = now;
                    press_count_next     = press_count + 1'b1;
                end
            end
            else if (!raw)
            begin
                flags.confirmed = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/debounced_press_rate_limiter.sv @@
`default_nettype none

// Channel  Handshake              Payload
// input    in_valid / in_stall    pin_level, now_time
// output   out_valid / out_stall  fired, event_sequence, event_time, raw_pressed, held_confirmed
// config   cfg_write              cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result goes from the input register
// through the single update stage into the result register, which sets the throughput.
// Reset restores the register defaults and clears the debounce and fire history.
// A stall on a valid output holds the result register and, once the input register
// is also full, raises in_stall in the same cycle.

module debounced_press_rate_limiter #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,

    input  wire logic                                    cfg_write,
    input  wire logic [dbpr_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [dbpr_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,

    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic                                    pin_level,
    input  wire logic [dbpr_pkg::STAMP_WIDTH-1:0]        now_time,

    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic                                         fired,
    output logic [dbpr_pkg::COUNT_WIDTH-1:0]             event_sequence,
    output logic [dbpr_pkg::STAMP_WIDTH-1:0]             event_time,
    output logic                                         raw_pressed,
    output logic                                         held_confirmed
);

    logic                                  active_low_reg;
    logic [dbpr_pkg::DEBOUNCE_WIDTH-1:0]   debounce_time_reg;
    logic [dbpr_pkg::INTERVAL_WIDTH-1:0]   min_interval_reg;

    logic                                  in_valid_reg;
    logic                                  pin_level_reg;
    logic [TIME_WIDTH-1:0]                 now_reg;

    logic                                  previous_raw_reg;
    logic [TIME_WIDTH-1:0]                 change_stamp_reg;
    logic                                  confirmed_reg;
    logic [TIME_WIDTH-1:0]                 last_fire_stamp_reg;
    logic [dbpr_pkg::COUNT_WIDTH-1:0]      press_count_reg;

    logic [TIME_WIDTH-1:0]                 change_stamp_next;
    logic [TIME_WIDTH-1:0]                 last_fire_stamp_next;
    logic [dbpr_pkg::COUNT_WIDTH-1:0]      press_count_next;
    dbpr_pkg::dbpr_flags_t                 flags;

    logic                                  out_valid_reg;
    logic                                  fired_reg;
    logic [dbpr_pkg::COUNT_WIDTH-1:0]      event_sequence_reg;
    logic [dbpr_pkg::STAMP_WIDTH-1:0]      event_time_reg;
    logic                                  raw_pressed_reg;
    logic                                  held_confirmed_reg;

    logic                                  advance;
    logic                                  in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg    <= dbpr_pkg::ACTIVE_LOW_RESET;
            debounce_time_reg <= dbpr_pkg::DEBOUNCE_TIME_RESET;
            min_interval_reg  <= dbpr_pkg::MIN_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dbpr_pkg::REG_ACTIVE_LOW:
                    active_low_reg <= cfg_data[0];
                dbpr_pkg::REG_DEBOUNCE_TIME:
                    debounce_time_reg <= cfg_data[dbpr_pkg::DEBOUNCE_WIDTH-1:0];
                dbpr_pkg::REG_MIN_INTERVAL:
                    min_interval_reg <= cfg_data[dbpr_pkg::INTERVAL_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pin_level_reg <= pin_level;
            // The time base is taken modulo 2^TIME_WIDTH.
            now_reg       <= TIME_WIDTH'(now_time);
        end
    end

    dbpr_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .active_low           (active_low_reg),
        .debounce_time        (debounce_time_reg),
        .min_interval         (min_interval_reg),
        .pin_level            (pin_level_reg),
        .now                  (now_reg),
        .previous_raw         (previous_raw_reg),
        .change_stamp         (change_stamp_reg),
        .confirmed            (confirmed_reg),
        .last_fire_stamp      (last_fire_stamp_reg),
        .press_count          (press_count_reg),
        .change_stamp_next    (change_stamp_next),
        .last_fire_stamp_next (last_fire_stamp_next),
        .press_count_next     (press_count_next),
        .flags                (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg    <= 1'b0;
            change_stamp_reg    <= '0;
            confirmed_reg       <= 1'b0;
            last_fire_stamp_reg <= '0;
            press_count_reg     <= '0;
        end
        else if (advance)
        begin
            previous_raw_reg    <= flags.raw;
            change_stamp_reg    <= change_stamp_next;
            confirmed_reg       <= flags.confirmed;
            last_fire_stamp_reg <= last_fire_stamp_next;
            press_count_reg     <= press_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg          <= flags.fire;
            event_sequence_reg <= press_count_next;
            event_time_reg     <= dbpr_pkg::STAMP_WIDTH'(last_fire_stamp_next);
            raw_pressed_reg    <= flags.raw;
            held_confirmed_reg <= flags.confirmed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fired          = fired_reg;
    assign event_sequence = event_sequence_reg;
    assign event_time     = event_time_reg;
    assign raw_pressed    = raw_pressed_reg;
    assign held_confirmed = held_confirmed_reg;

endmodule

`default_nettype wire
